// ===== design/fpsa_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the fit-policy segment allocator.
// No dependencies; every other file imports this package.
package fpsa_pkg;

  localparam int SEG_W   = 16;  // start / size field width on the ports
  localparam int SIZE_W  = 16;  // stored segment size width
  localparam int OWNER_W = 8;
  localparam int HIDX_W  = 5;

  localparam logic [1:0] MODE_FIRST = 2'd0;
  localparam logic [1:0] MODE_BEST  = 2'd1;
  localparam logic [1:0] MODE_WORST = 2'd2;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_ALLOC  = 1'b1;

  typedef enum logic [1:0] {
    ST_ALLOC  = 2'd0,
    ST_NOFIT  = 2'd1,
    ST_FULL   = 2'd2,
    ST_APPEND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_EXACT  = 2'd2,
    CMD_INSERT = 2'd3
  } cmd_kind_t;

  // Table update broadcast to every cell in the row.
  typedef struct packed {
    cmd_kind_t            kind;
    logic                 hole;
    logic [OWNER_W-1:0]   owner;
    logic [SIZE_W-1:0]    size;
    logic [SIZE_W-1:0]    rem;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INJECT,
    S_SCAN,
    S_COMMIT
  } state_t;

endpackage

// ===== design/fpsa_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the segment allocator:
// configuration write, request in, result out. Depends on fpsa_pkg.
interface fpsa_cfg_if;
  import fpsa_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] fit_mode;
  modport source (output valid, output fit_mode, input ready);
  modport sink   (input valid, input fit_mode, output ready);
endinterface

interface fpsa_req_if;
  import fpsa_pkg::*;
  logic               valid;
  logic               ready;
  logic               op;
  logic [SEG_W-1:0]   seg_start;
  logic [SEG_W-1:0]   seg_size;
  logic               seg_is_hole;
  logic [OWNER_W-1:0] owner_id;
  logic [SEG_W-1:0]   request_size;
  modport source (output valid, output op, output seg_start, output seg_size,
                  output seg_is_hole, output owner_id, output request_size,
                  input ready);
  modport sink   (input valid, input op, input seg_start, input seg_size,
                  input seg_is_hole, input owner_id, input request_size,
                  output ready);
endinterface

interface fpsa_rsp_if;
  import fpsa_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [SEG_W-1:0]  alloc_start;
  logic [HIDX_W-1:0] hole_index;
  modport source (output valid, output status, output alloc_start,
                  output hole_index, input ready);
  modport sink   (input valid, input status, input alloc_start,
                  input hole_index, output ready);
endinterface

// ===== design/fit_policy_segment_allocator_top.sv =====
`timescale 1ns / 1ps
// Top level of the fit-policy segment allocator: control, result register
// and the row of fpsa_cell slots. Depends on fpsa_pkg, fpsa_if, fpsa_cell.

// The block keeps an ordered table of TABLE_ENTRIES segments, one per cell
// in a row. An append request (op 0) writes the next free cell; it passes
// through the commit state, which registers its result, and the next
// request can be accepted once the block is back in idle. An allocate request
// (op 1) injects a search token at the head of the row; the token walks one
// cell per cycle, each cell replacing it with its own hole when that hole
// wins under the current fit_mode. After the walk the token is latched as
// it leaves the last cell, the commit state registers the result, and the
// next request is accepted once the block is back in idle. The commit step
// then updates every cell at once: the chosen hole shrinks (or becomes the
// allocation on an exact fit), and cells after it shift down one place to
// make room. One request is worked at a time; a new one is accepted while
// the previous result still waits in the output register, and a held result
// stalls the commit until that register is free. The configuration channel
// is always ready; write fit_mode only while the block is idle. Table
// contents power up undefined; reset clears the segment count, the state,
// fit_mode (to first fit) and the result valid flag.
module fit_policy_segment_allocator_top #(
  parameter int TABLE_ENTRIES = 16,
  parameter int ADDR_BITS     = 16
) (
  input logic       clk,
  input logic       rst,
  fpsa_cfg_if.sink  cfg,
  fpsa_req_if.sink  req,
  fpsa_rsp_if.source rsp
);
  import fpsa_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  state_t state, state_next;

  // Registered request fields.
  logic                op;
  logic [SEG_W-1:0]    seg_start;
  logic [SEG_W-1:0]    seg_size;
  logic                seg_is_hole;
  logic [OWNER_W-1:0]  owner_id;
  logic [SIZE_W-1:0]   request_size;

  logic [1:0]          fit_mode;
  logic [CW-1:0]       seg_count, seg_count_next;

  // Token latched as it leaves the last cell.
  logic                fin_found;
  logic [IW-1:0]       fin_idx;
  logic [SIZE_W-1:0]   fin_size;
  logic [ADDR_BITS-1:0] fin_start;

  // Result register.
  logic                rsp_valid;
  status_t             rsp_status;
  logic [SEG_W-1:0]    rsp_start;
  logic [HIDX_W-1:0]   rsp_hidx;

  logic                rsp_load;
  status_t             status_next;
  logic [SEG_W-1:0]    start_next;
  logic [HIDX_W-1:0]   hidx_next;

  logic                tok_inject;
  cell_cmd_t           cmd;
  logic [IW-1:0]       cmd_pos;
  logic [ADDR_BITS-1:0] cmd_start;

  logic                table_full;
  logic                fit_ok;
  logic [SIZE_W-1:0]   rem;
  logic [ADDR_BITS-1:0] top_addr;
  logic [HIDX_W-1:0]   hidx_fin;

  // Row wiring: index i feeds cell i, index i+1 is its output.
  logic                 tok_v     [0:TABLE_ENTRIES];
  logic                 tok_found [0:TABLE_ENTRIES];
  logic [IW-1:0]        tok_idx   [0:TABLE_ENTRIES];
  logic [SIZE_W-1:0]    tok_size  [0:TABLE_ENTRIES];
  logic [ADDR_BITS-1:0] tok_start [0:TABLE_ENTRIES];

  logic [ADDR_BITS-1:0] e_start [0:TABLE_ENTRIES];
  logic [SIZE_W-1:0]    e_size  [0:TABLE_ENTRIES];
  logic                 e_hole  [0:TABLE_ENTRIES];
  logic [OWNER_W-1:0]   e_owner [0:TABLE_ENTRIES];

  assign cfg.ready = 1'b1;
  assign req.ready = (state == S_IDLE);

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.alloc_start = rsp_start;
  assign rsp.hole_index  = rsp_hidx;

  // Fresh token enters the head of the row with nothing found.
  assign tok_v[0]     = tok_inject;
  assign tok_found[0] = 1'b0;
  assign tok_idx[0]   = '0;
  assign tok_size[0]  = '0;
  assign tok_start[0] = '0;

  // Head cell never shifts; tie its upstream entry off.
  assign e_start[0] = '0;
  assign e_size[0]  = '0;
  assign e_hole[0]  = 1'b0;
  assign e_owner[0] = '0;

  genvar g;
  generate
    for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      fpsa_cell #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ADDR_BITS     (ADDR_BITS),
        .CELL_IDX      (g)
      ) u_cell (
        .clk           (clk),
        .rst           (rst),
        .cell_count    (seg_count),
        .mode          (fit_mode),
        .req_size      (request_size),
        .tok_in_valid  (tok_v[g]),
        .tok_in_found  (tok_found[g]),
        .tok_in_idx    (tok_idx[g]),
        .tok_in_size   (tok_size[g]),
        .tok_in_start  (tok_start[g]),
        .tok_out_valid (tok_v[g+1]),
        .tok_out_found (tok_found[g+1]),
        .tok_out_idx   (tok_idx[g+1]),
        .tok_out_size  (tok_size[g+1]),
        .tok_out_start (tok_start[g+1]),
        .cmd           (cmd),
        .cmd_pos       (cmd_pos),
        .cmd_start     (cmd_start),
        .up_start      (e_start[g]),
        .up_size       (e_size[g]),
        .up_hole       (e_hole[g]),
        .up_owner      (e_owner[g]),
        .ent_start     (e_start[g+1]),
        .ent_size      (e_size[g+1]),
        .ent_hole      (e_hole[g+1]),
        .ent_owner     (e_owner[g+1])
      );
    end
  endgenerate

  // Placement arithmetic on the winning hole.
  assign table_full = (seg_count == CW'(TABLE_ENTRIES));
  assign fit_ok     = fin_found && (fin_size >= request_size);
  assign rem        = fin_size - request_size;
  assign top_addr   = fin_start + ADDR_BITS'(rem);
  assign hidx_fin   = HIDX_W'((IW + 1)'(fin_idx) + 1'b1);

  always_comb begin
    state_next     = state;
    seg_count_next = seg_count;
    tok_inject     = 1'b0;
    rsp_load       = 1'b0;
    status_next    = ST_NOFIT;
    start_next     = '0;
    hidx_next      = '0;
    cmd            = '{kind: CMD_NONE, hole: 1'b0, owner: owner_id,
                       size: request_size, rem: rem};
    cmd_pos        = fin_idx;
    cmd_start      = top_addr;

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = (req.op == OP_ALLOC) ? S_INJECT : S_COMMIT;
        end
      end
      S_INJECT: begin
        tok_inject = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (tok_v[TABLE_ENTRIES]) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        // Hold until the result register is free.
        if (!rsp_valid || rsp.ready) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
          if (op == OP_APPEND) begin
            if (table_full) begin
              status_next = ST_FULL;
            end else begin
              status_next    = ST_APPEND;
              cmd.kind       = CMD_APPEND;
              cmd.hole       = seg_is_hole;
              cmd.size       = seg_size;
              cmd_pos        = IW'(seg_count);
              cmd_start      = ADDR_BITS'(seg_start);
              seg_count_next = seg_count + 1'b1;
            end
          end else if (!fit_ok) begin
            status_next = ST_NOFIT;
          end else if (rem == '0) begin
            // Exact fit: the hole itself becomes the allocation.
            status_next = ST_ALLOC;
            start_next  = SEG_W'(top_addr);
            hidx_next   = hidx_fin;
            cmd.kind    = CMD_EXACT;
          end else if (table_full) begin
            status_next = ST_FULL;
            hidx_next   = hidx_fin;
          end else begin
            // Carve from the top and insert right after the hole.
            status_next    = ST_ALLOC;
            start_next     = SEG_W'(top_addr);
            hidx_next      = hidx_fin;
            cmd.kind       = CMD_INSERT;
            seg_count_next = seg_count + 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      seg_count <= '0;
      fit_mode  <= MODE_FIRST;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      seg_count <= seg_count_next;
      if (cfg.valid) begin
        fit_mode <= cfg.fit_mode;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers: request capture, final token, result.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op           <= req.op;
      seg_start    <= req.seg_start;
      seg_size     <= req.seg_size;
      seg_is_hole  <= req.seg_is_hole;
      owner_id     <= req.owner_id;
      request_size <= req.request_size;
    end
    if (state == S_SCAN && tok_v[TABLE_ENTRIES]) begin
      fin_found <= tok_found[TABLE_ENTRIES];
      fin_idx   <= tok_idx[TABLE_ENTRIES];
      fin_size  <= tok_size[TABLE_ENTRIES];
      fin_start <= tok_start[TABLE_ENTRIES];
    end
    if (rsp_load) begin
      rsp_status <= status_next;
      rsp_start  <= start_next;
      rsp_hidx   <= hidx_next;
    end
  end

  // Table never holds more segments than it has cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    seg_count <= CW'(TABLE_ENTRIES))
    else $error("segment count beyond table size");

  // Count grows by at most one per request.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    seg_count == $past(seg_count) || seg_count == $past(seg_count) + 1'b1)
    else $error("segment count jumped");

  // The search token only leaves the row while the controller waits for it.
  a_token_scan: assert property (@(posedge clk) disable iff (rst)
    tok_v[TABLE_ENTRIES] |-> state == S_SCAN)
    else $error("search token left the row outside scan");

  // A new result appears only out of the commit step.
  a_rsp_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_COMMIT)
    else $error("result raised outside commit");

endmodule

// ===== design/fpsa_cell.sv =====
`timescale 1ns / 1ps
// One table slot of the allocator row: holds a segment, refines the
// passing search token, and shifts entries on insert. Depends on fpsa_pkg.
module fpsa_cell #(
  parameter int TABLE_ENTRIES = 16,
  parameter int ADDR_BITS     = 16,
  parameter int CELL_IDX      = 0,
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
  localparam int CW = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [CW-1:0]                  cell_count,
  input  logic [1:0]                     mode,
  input  logic [fpsa_pkg::SIZE_W-1:0]    req_size,
  input  logic                           tok_in_valid,
  input  logic                           tok_in_found,
  input  logic [IW-1:0]                  tok_in_idx,
  input  logic [fpsa_pkg::SIZE_W-1:0]    tok_in_size,
  input  logic [ADDR_BITS-1:0]           tok_in_start,
  output logic                           tok_out_valid,
  output logic                           tok_out_found,
  output logic [IW-1:0]                  tok_out_idx,
  output logic [fpsa_pkg::SIZE_W-1:0]    tok_out_size,
  output logic [ADDR_BITS-1:0]           tok_out_start,
  input  fpsa_pkg::cell_cmd_t            cmd,
  input  logic [IW-1:0]                  cmd_pos,
  input  logic [ADDR_BITS-1:0]           cmd_start,
  input  logic [ADDR_BITS-1:0]           up_start,
  input  logic [fpsa_pkg::SIZE_W-1:0]    up_size,
  input  logic                           up_hole,
  input  logic [fpsa_pkg::OWNER_W-1:0]   up_owner,
  output logic [ADDR_BITS-1:0]           ent_start,
  output logic [fpsa_pkg::SIZE_W-1:0]    ent_size,
  output logic                           ent_hole,
  output logic [fpsa_pkg::OWNER_W-1:0]   ent_owner
);
  import fpsa_pkg::*;

  logic          live;
  logic          fits;
  logic          take;
  logic [IW:0]   me;
  logic [IW:0]   pos_ext;

  assign live    = (CW'(CELL_IDX) < cell_count);
  assign fits    = (ent_size >= req_size);
  assign me      = (IW + 1)'(CELL_IDX);
  assign pos_ext = {1'b0, cmd_pos};

  always_comb begin
    unique case (mode)
      MODE_BEST:  take = live && ent_hole && fits &&
                         (!tok_in_found || ent_size < tok_in_size);
      MODE_WORST: take = live && ent_hole &&
                         (!tok_in_found || ent_size > tok_in_size);
      default:    take = live && ent_hole && fits && !tok_in_found;
    endcase
  end

  // Search token: advance one cell per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out_valid <= 1'b0;
    end else begin
      tok_out_valid <= tok_in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tok_out_found <= 1'b1;
      tok_out_idx   <= IW'(CELL_IDX);
      tok_out_size  <= ent_size;
      tok_out_start <= ent_start;
    end else begin
      tok_out_found <= tok_in_found;
      tok_out_idx   <= tok_in_idx;
      tok_out_size  <= tok_in_size;
      tok_out_start <= tok_in_start;
    end
  end

  // Segment entry.
  always_ff @(posedge clk) begin
    unique case (cmd.kind)
      CMD_APPEND, CMD_EXACT: begin
        if (me == pos_ext) begin
          ent_start <= cmd_start;
          ent_size  <= cmd.size;
          ent_hole  <= cmd.hole;
          ent_owner <= cmd.owner;
        end
      end
      CMD_INSERT: begin
        priority if (me == pos_ext) begin
          ent_size <= cmd.rem;
        end else if (me == pos_ext + 1'b1) begin
          ent_start <= cmd_start;
          ent_size  <= cmd.size;
          ent_hole  <= cmd.hole;
          ent_owner <= cmd.owner;
        end else if (me > pos_ext + 1'b1) begin
          ent_start <= up_start;
          ent_size  <= up_size;
          ent_hole  <= up_hole;
          ent_owner <= up_owner;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
